[rtl/core/apc_pkg.sv]
package apc_pkg;

    // sample width and derived widths
    localparam int SAMPLE_BITS = 24;
    localparam int THR_BITS    = 23;
    localparam int GAIN_BITS   = 8;
    localparam int COEF_BITS   = 8;
    localparam int ACC_BITS    = SAMPLE_BITS + GAIN_BITS;
    localparam int NUM_BITS    = THR_BITS + GAIN_BITS;
    localparam int CMP_BITS    = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
    localparam int CNT_BITS    = $clog2(SAMPLE_BITS + 1);
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = THR_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [SAMPLE_BITS-1:0]        t_mag;
    typedef logic [ACC_BITS-1:0]           t_acc;
    typedef logic [NUM_BITS-1:0]           t_num;
    typedef logic [CMP_BITS-1:0]           t_cmp;
    typedef logic [CNT_BITS-1:0]           t_cnt;
    typedef logic [THR_BITS-1:0]           t_thr;
    typedef logic [GAIN_BITS-1:0]          t_gain;
    typedef logic [COEF_BITS-1:0]          t_coef;
    typedef logic [CFG_IDX_BITS-1:0]       t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0]      t_cfg_data;

    // unity gain and register reset values
    localparam t_gain GAIN_ONE      = t_gain'(255);
    localparam t_thr  THR_RESET     = t_thr'(31000);
    localparam t_coef ATTACK_RESET  = t_coef'(10);
    localparam t_coef RELEASE_RESET = t_coef'(200);

    // register indexes
    localparam t_cfg_idx CFG_THRESHOLD = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_ATTACK    = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_RELEASE   = t_cfg_idx'(2);

    // divider request and response
    typedef struct packed {
        logic start;
        t_mag rem;
        t_mag low;
        t_mag divisor;
        t_cnt steps;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_mag quo;
    } t_div_rsp;

endpackage

[rtl/core/apc_serial_div.sv]
module apc_serial_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  apc_pkg::t_div_req i_req,
    output apc_pkg::t_div_rsp o_rsp
);
    import apc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    t_cnt                 r_cnt;
    t_mag                 r_rem;
    t_mag                 r_low;
    t_mag                 r_div;
    t_mag                 r_quo;
    logic [SAMPLE_BITS:0] w_trial;
    logic [SAMPLE_BITS:0] w_diff;
    logic                 w_ge;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        w_trial = {r_rem, r_low[SAMPLE_BITS-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - t_cnt'(1);
                if (r_cnt == t_cnt'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_low <= i_req.low;
            r_div <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[SAMPLE_BITS-1:0] : w_trial[SAMPLE_BITS-1:0];
            r_low <= r_low << 1;
            r_quo <= {r_quo[SAMPLE_BITS-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

[rtl/core/audio_peak_compressor.sv]
// Peak compressor for signed audio with a smoothed gain.
// Input channel: i_in_valid / o_in_stall with i_sample_in; a transfer happens
// at a rising edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with o_sample_out and
// o_applied_gain (255 is unity); one result per input sample.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 threshold, 1 attack coefficient, 2 release coefficient, any other
// index is dropped. Write only while no sample is in flight.
// The bit-serial datapath runs an 8-step gain division (skipped when the
// magnitude is within the threshold), an 8-step smoothing multiply, an 8-step
// divide by 255, an 8-step output multiply and a SAMPLE_BITS-step divide by
// 255; the three divisions go through one shared serial divider.
// The core takes no new sample until the previous result sits in the output
// register; the next input is then taken even while the output is stalled.
// Reset (synchronous, active low) restores threshold 31000, attack 10,
// release 200 and a smoothed gain of zero, and empties the output register.
// A stalled result holds its value; the core waits only if a new result is
// ready while the old one has not been taken.
module audio_peak_compressor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  apc_pkg::t_sample    i_sample_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output apc_pkg::t_sample    o_sample_out,
    output apc_pkg::t_gain      o_applied_gain,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  apc_pkg::t_cfg_idx   i_cfg_index,
    input  apc_pkg::t_cfg_data  i_cfg_data
);
    import apc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_GAIN  = 4'd2;
    localparam logic [3:0] S_SMSET = 4'd3;
    localparam logic [3:0] S_SMUL  = 4'd4;
    localparam logic [3:0] S_SDIV  = 4'd5;
    localparam logic [3:0] S_OMUL  = 4'd6;
    localparam logic [3:0] S_ODIV  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state, n_state;
    t_thr       r_threshold;
    t_coef      r_attack;
    t_coef      r_release;
    t_gain      r_smoothed, n_smoothed;
    t_mag       r_mag, n_mag;
    logic       r_neg, n_neg;
    t_gain      r_gain, n_gain;
    t_acc       r_acc, n_acc;
    t_gain      r_ma, n_ma;
    t_gain      r_mb, n_mb;
    t_mag       r_xa, n_xa;
    t_gain      r_xb, n_xb;
    logic [2:0] r_mcnt, n_mcnt;
    t_mag       r_omag, n_omag;
    logic       r_out_valid, n_out_valid;
    t_mag       r_out_sample, n_out_sample;
    t_gain      r_out_gain, n_out_gain;

    t_div_req   w_div_req;
    t_div_rsp   w_div_rsp;
    t_num       w_num;
    t_coef      w_weight;
    t_acc       w_mac;
    logic       w_out_free;
    logic       w_in_xfer;

    apc_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // threshold times 255 as a shift and subtract
    assign w_num    = {r_threshold, 8'd0} - {8'd0, r_threshold};
    assign w_weight = (r_smoothed > r_gain) ? r_attack : r_release;

    // msb-first shift-add step for both multipliers
    assign w_mac = (r_acc << 1)
                 + (r_ma[GAIN_BITS-1] ? t_acc'(r_xa) : '0)
                 + (r_mb[GAIN_BITS-1] ? t_acc'(r_xb) : '0);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_smoothed   = r_smoothed;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_gain       = r_gain;
        n_acc        = r_acc;
        n_ma         = r_ma;
        n_mb         = r_mb;
        n_xa         = r_xa;
        n_xb         = r_xb;
        n_mcnt       = r_mcnt;
        n_omag       = r_omag;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_gain   = r_out_gain;
        w_div_req    = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_neg   = i_sample_in[SAMPLE_BITS-1];
                    n_mag   = n_neg ? (~$unsigned(i_sample_in) + t_mag'(1))
                                    : $unsigned(i_sample_in);
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (t_cmp'(r_mag) > t_cmp'(r_threshold)) begin
                    // quotient is below 255, so 8 steps suffice
                    w_div_req.start   = 1'b1;
                    w_div_req.rem     = t_mag'(w_num[NUM_BITS-1:8]);
                    w_div_req.low     = t_mag'(w_num[7:0]) << (SAMPLE_BITS - 8);
                    w_div_req.divisor = r_mag;
                    w_div_req.steps   = t_cnt'(GAIN_BITS);
                    n_state = S_GAIN;
                end else begin
                    n_gain  = GAIN_ONE;
                    n_state = S_SMSET;
                end
            end
            S_GAIN: begin
                if (w_div_rsp.done) begin
                    n_gain  = w_div_rsp.quo[GAIN_BITS-1:0];
                    n_state = S_SMSET;
                end
            end
            S_SMSET: begin
                n_acc   = '0;
                n_ma    = w_weight;
                n_mb    = GAIN_ONE - w_weight;
                n_xa    = t_mag'(r_smoothed);
                n_xb    = r_gain;
                n_mcnt  = '0;
                n_state = S_SMUL;
            end
            S_SMUL: begin
                n_acc  = w_mac;
                n_ma   = r_ma << 1;
                n_mb   = r_mb << 1;
                n_mcnt = r_mcnt + 3'd1;
                if (r_mcnt == 3'd7) begin
                    // weighted sum over 255, quotient fits 8 bits
                    w_div_req.start   = 1'b1;
                    w_div_req.rem     = t_mag'(w_mac[15:8]);
                    w_div_req.low     = t_mag'(w_mac[7:0]) << (SAMPLE_BITS - 8);
                    w_div_req.divisor = t_mag'(GAIN_ONE);
                    w_div_req.steps   = t_cnt'(GAIN_BITS);
                    n_state = S_SDIV;
                end
            end
            S_SDIV: begin
                if (w_div_rsp.done) begin
                    n_smoothed = w_div_rsp.quo[GAIN_BITS-1:0];
                    n_acc      = '0;
                    n_ma       = w_div_rsp.quo[GAIN_BITS-1:0];
                    n_mb       = '0;
                    n_xa       = r_mag;
                    n_xb       = '0;
                    n_mcnt     = '0;
                    n_state    = S_OMUL;
                end
            end
            S_OMUL: begin
                n_acc  = w_mac;
                n_ma   = r_ma << 1;
                n_mb   = r_mb << 1;
                n_mcnt = r_mcnt + 3'd1;
                if (r_mcnt == 3'd7) begin
                    // magnitude times gain over 255
                    w_div_req.start   = 1'b1;
                    w_div_req.rem     = t_mag'(w_mac[ACC_BITS-1:SAMPLE_BITS]);
                    w_div_req.low     = w_mac[SAMPLE_BITS-1:0];
                    w_div_req.divisor = t_mag'(GAIN_ONE);
                    w_div_req.steps   = t_cnt'(SAMPLE_BITS);
                    n_state = S_ODIV;
                end
            end
            S_ODIV: begin
                if (w_div_rsp.done) begin
                    n_omag  = w_div_rsp.quo;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_neg ? (~r_omag + t_mag'(1)) : r_omag;
                    n_out_gain   = r_smoothed;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_smoothed  <= '0;
            r_threshold <= THR_RESET;
            r_attack    <= ATTACK_RESET;
            r_release   <= RELEASE_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_smoothed  <= n_smoothed;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_BITS-1:0];
                    CFG_ATTACK:    r_attack    <= i_cfg_data[COEF_BITS-1:0];
                    CFG_RELEASE:   r_release   <= i_cfg_data[COEF_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_mag        <= n_mag;
        r_neg        <= n_neg;
        r_gain       <= n_gain;
        r_acc        <= n_acc;
        r_ma         <= n_ma;
        r_mb         <= n_mb;
        r_xa         <= n_xa;
        r_xb         <= n_xb;
        r_mcnt       <= n_mcnt;
        r_omag       <= n_omag;
        r_out_sample <= n_out_sample;
        r_out_gain   <= n_out_gain;
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_out   = $signed(r_out_sample);
    assign o_applied_gain = r_out_gain;

`ifndef SYNTHESIS
    // divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_GAIN || r_state == S_SDIV || r_state == S_ODIV))
        else $error("divider done outside a divide state");

    // gain and smoothing quotients fit in 8 bits
    a_gain_quo_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_rsp.done && (r_state == S_GAIN || r_state == S_SDIV))
        |-> (w_div_rsp.quo >> GAIN_BITS) == '0)
        else $error("gain quotient exceeds 8 bits");

    // instantaneous gain from division stays below unity
    a_gain_below_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_rsp.done && r_state == S_GAIN) |-> w_div_rsp.quo[GAIN_BITS-1:0] != GAIN_ONE)
        else $error("divided gain reached unity");

    // a finished sample lands in the output register when it is free
    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not loaded into output register");
`endif

endmodule
